[rtl/hkrt_pkg.sv]
// Package for the HID keyboard report tracker.
// Holds item, job and report types, command and key type codes and the US layout.
// No dependencies.
package hkrt_pkg;

   localparam int KEY_SLOTS   = 6;
   localparam int RPT_SLOTS   = 6;
   localparam int MAP_ENTRIES = 256;
   localparam int MAP_AW      = $clog2(MAP_ENTRIES);
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int DEAD_KEYS   = 6;
   localparam int CSR_IDX_W   = 3;
   localparam int DEAD_W      = 10;
   localparam int TYPE_STEPS  = 8;
   localparam int STEP_W      = $clog2(TYPE_STEPS);

   typedef enum logic [1:0] {
      CMD_PRESS   = 2'd0,
      CMD_RELEASE = 2'd1,
      CMD_TYPE    = 2'd2,
      CMD_WRITE   = 2'd3
   } command_type;

   localparam logic [3:0] KT_MODIFIER   = 4'd0;
   localparam logic [3:0] KT_SPECIAL    = 4'd1;
   localparam logic [3:0] KT_CHAR       = 4'd2;
   localparam logic [3:0] KT_DEAD_FIRST = 4'd3;
   localparam logic [3:0] KT_DEAD_LAST  = 4'd8;

   localparam logic [2:0] STEP_DEAD_PRESS    = 3'd0;
   localparam logic [2:0] STEP_SHIFT_PRESS   = 3'd1;
   localparam logic [2:0] STEP_ALTGR_PRESS   = 3'd2;
   localparam logic [2:0] STEP_KEY_PRESS     = 3'd3;
   localparam logic [2:0] STEP_KEY_RELEASE   = 3'd4;
   localparam logic [2:0] STEP_ALTGR_RELEASE = 3'd5;
   localparam logic [2:0] STEP_SHIFT_RELEASE = 3'd6;
   localparam logic [2:0] STEP_DEAD_RELEASE  = 3'd7;

   localparam logic [7:0] MOD_LSHIFT = 8'h02;
   localparam logic [7:0] MOD_RALT   = 8'h40;
   localparam int         FLAG_SHIFT = 8;
   localparam int         FLAG_ALTGR = 9;

   localparam logic [7:0] UTF8_LEAD_C2  = 8'hC2;
   localparam logic [7:0] UTF8_LEAD_C3  = 8'hC3;
   localparam logic [7:0] UTF8_HIGH_SET = 8'hC0;
   localparam logic [7:0] EURO_LEAD     = 8'h82;
   localparam logic [7:0] EURO_TRAIL    = 8'hAC;
   localparam logic [7:0] EURO_CHAR     = 8'h80;

   typedef enum logic {F_IDLE, F_LOOK} front_state_type;
   typedef enum logic {B_IDLE, B_RUN} back_state_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [3:0]  key_type;
      logic [7:0]  key_code;
      logic        use_mod;
      logic [15:0] map_entry;
   } req_item_type;

   typedef struct packed {
      logic [7:0] modifiers;
      logic [7:0] slot_zero;
      logic [7:0] slot_one;
      logic [7:0] slot_two;
      logic [7:0] slot_three;
      logic [7:0] slot_four;
      logic [7:0] slot_five;
      logic       last;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [3:0]  key_type;
      logic [7:0]  key_code;
      logic        use_mod;
      logic [15:0] entry;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   localparam logic [9:0] US_LAYOUT [128] = '{
      10'h000, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000,
      10'h02a, 10'h02b, 10'h028, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000,
      10'h000, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000,
      10'h000, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000,
      10'h02c, 10'h11e, 10'h134, 10'h120, 10'h121, 10'h122, 10'h124, 10'h034,
      10'h126, 10'h127, 10'h125, 10'h12e, 10'h036, 10'h02d, 10'h037, 10'h038,
      10'h027, 10'h01e, 10'h01f, 10'h020, 10'h021, 10'h022, 10'h023, 10'h024,
      10'h025, 10'h026, 10'h133, 10'h033, 10'h136, 10'h02e, 10'h137, 10'h138,
      10'h11f, 10'h104, 10'h105, 10'h106, 10'h107, 10'h108, 10'h109, 10'h10a,
      10'h10b, 10'h10c, 10'h10d, 10'h10e, 10'h10f, 10'h110, 10'h111, 10'h112,
      10'h113, 10'h114, 10'h115, 10'h116, 10'h117, 10'h118, 10'h119, 10'h11a,
      10'h11b, 10'h11c, 10'h11d, 10'h02f, 10'h031, 10'h030, 10'h123, 10'h12d,
      10'h035, 10'h004, 10'h005, 10'h006, 10'h007, 10'h008, 10'h009, 10'h00a,
      10'h00b, 10'h00c, 10'h00d, 10'h00e, 10'h00f, 10'h010, 10'h011, 10'h012,
      10'h013, 10'h014, 10'h015, 10'h016, 10'h017, 10'h018, 10'h019, 10'h01a,
      10'h01b, 10'h01c, 10'h01d, 10'h12f, 10'h131, 10'h130, 10'h135, 10'h000
   };

   function automatic logic [15:0] us_layout_entry(input logic [7:0] idx);
      logic [15:0] val;
      val = 16'h0000;
      if (!idx[7]) begin
         val = {6'b000000, US_LAYOUT[idx[6:0]]};
      end
      return val;
   endfunction

endpackage

[rtl/hid_keyboard_report_tracker_top.sv]
// Flow: the front end accepts an item and reads its layout map entry, then pushes a job into
// the queue; the back end plays the job's steps and sends one report per step it plays.
// After each acting item the input stalls until its job is pushed or dropped. The back end
// loads one job at a time, plays up to 8 steps for a typed byte and holds on rsp_stall.
// Reset clears report state, UTF-8 lead, dead key registers and layout map valid bits at once;
// the map then reads as the built-in US layout until an entry is written.
module hid_keyboard_report_tracker_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  hkrt_pkg::req_item_type              req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output hkrt_pkg::rsp_item_type              rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [hkrt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [hkrt_pkg::DEAD_W-1:0]         csr_wdata
);

   logic                       q_push;
   logic                       q_pop;
   hkrt_pkg::job_type          push_job;
   hkrt_pkg::job_type          head_job;
   hkrt_pkg::queue_status_type q_status;

   hkrt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .push      (q_push),
      .push_job  (push_job),
      .q_status  (q_status)
   );

   hkrt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (head_job),
      .q_status (q_status)
   );

   hkrt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_job  (head_job),
      .q_status  (q_status),
      .pop       (q_pop),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_status.full)
      else $error("job pushed into a full queue");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("job popped from an empty queue");

   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("front end not ready after reset");

   a_no_job_while_queued_empty: assert property (@(posedge clock) disable iff (reset)
      (q_status.empty && !q_push) |=> !q_pop || q_status.empty == 1'b0)
      else $error("pop with no job queued");

endmodule

[rtl/hkrt_front.sv]
// Front end: accepts items, folds UTF-8, owns the layout map and resolves lookups.
// Pushes one job per acting item into the queue. Depends on hkrt_pkg.
module hkrt_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  hkrt_pkg::req_item_type       req_data,
   output logic                         push,
   output hkrt_pkg::job_type            push_job,
   input  hkrt_pkg::queue_status_type   q_status
);

   hkrt_pkg::front_state_type state_ff, state_in;
   logic [7:0]                lead_ff, lead_in;
   logic [hkrt_pkg::MAP_ENTRIES-1:0] map_vld_ff;
   logic [15:0]               map_mem [hkrt_pkg::MAP_ENTRIES];
   logic [15:0]               map_rdata_ff;
   logic                      map_rvld_ff;
   logic                      in_range_ff;
   logic [1:0]                cmd_ff;
   logic [3:0]                type_ff;
   logic [7:0]                code_ff;
   logic                      use_ff;

   logic                      accept;
   logic                      is_type;
   logic [7:0]                folded;
   logic [7:0]                rd_idx;
   logic                      in_range;
   logic [hkrt_pkg::MAP_AW-1:0] map_addr;
   logic                      map_wr;
   logic [15:0]               entry;
   logic                      drop;

   assign accept   = req_valid && (state_ff == hkrt_pkg::F_IDLE);
   assign req_stall = (state_ff != hkrt_pkg::F_IDLE);
   assign is_type  = (req_data.command == hkrt_pkg::CMD_TYPE);

   always_comb begin
      folded  = req_data.key_code;
      lead_in = lead_ff;
      if (accept && is_type) begin
         if (!req_data.key_code[7]) begin
            lead_in = 8'h00;
         end else begin
            lead_in = req_data.key_code;
            if (lead_ff == hkrt_pkg::UTF8_LEAD_C2) begin
               folded = req_data.key_code;
            end else if (lead_ff == hkrt_pkg::UTF8_LEAD_C3) begin
               folded = req_data.key_code | hkrt_pkg::UTF8_HIGH_SET;
            end else if (lead_ff == hkrt_pkg::EURO_LEAD &&
                         req_data.key_code == hkrt_pkg::EURO_TRAIL) begin
               folded = hkrt_pkg::EURO_CHAR;
            end else begin
               folded = 8'h00;
            end
         end
      end
   end

   assign rd_idx   = is_type ? folded : req_data.key_code;
   assign in_range = ({1'b0, rd_idx} < 9'(hkrt_pkg::MAP_ENTRIES));
   assign map_addr = rd_idx[hkrt_pkg::MAP_AW-1:0];
   assign map_wr   = accept && (req_data.command == hkrt_pkg::CMD_WRITE) && in_range;

   always_comb begin
      if (!in_range_ff) begin
         entry = 16'h0000;
      end else if (map_rvld_ff) begin
         entry = map_rdata_ff;
      end else begin
         entry = hkrt_pkg::us_layout_entry(code_ff);
      end
   end

   assign drop = (cmd_ff == hkrt_pkg::CMD_TYPE) && (entry == 16'h0000);

   always_comb begin
      state_in = state_ff;
      push     = 1'b0;
      case (state_ff)
         hkrt_pkg::F_IDLE: begin
            if (accept && req_data.command != hkrt_pkg::CMD_WRITE &&
                !(is_type && folded == 8'h00)) begin
               state_in = hkrt_pkg::F_LOOK;
            end
         end
         hkrt_pkg::F_LOOK: begin
            if (drop) begin
               state_in = hkrt_pkg::F_IDLE;
            end else if (!q_status.full) begin
               push     = 1'b1;
               state_in = hkrt_pkg::F_IDLE;
            end
         end
         default: begin
            state_in = hkrt_pkg::F_IDLE;
         end
      endcase
   end

   assign push_job = '{command: cmd_ff, key_type: type_ff, key_code: code_ff,
                       use_mod: use_ff, entry: entry};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= hkrt_pkg::F_IDLE;
         lead_ff    <= 8'h00;
         map_vld_ff <= '0;
      end else begin
         state_ff <= state_in;
         lead_ff  <= lead_in;
         if (map_wr) begin
            map_vld_ff[map_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff      <= req_data.command;
         type_ff     <= req_data.key_type;
         code_ff     <= rd_idx;
         use_ff      <= req_data.use_mod;
         in_range_ff <= in_range;
         map_rvld_ff <= map_vld_ff[map_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (map_wr) begin
         map_mem[map_addr] <= req_data.map_entry;
      end
      if (accept) begin
         map_rdata_ff <= map_mem[map_addr];
      end
   end

endmodule

[rtl/hkrt_queue.sv]
// Short job queue between the front end and the back end.
// Depends on hkrt_pkg for the job type and depth.
module hkrt_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  hkrt_pkg::job_type           push_job,
   input  logic                        pop,
   output hkrt_pkg::job_type           head_job,
   output hkrt_pkg::queue_status_type  q_status
);

   hkrt_pkg::job_type            slot_ff [hkrt_pkg::QUEUE_DEPTH];
   logic [hkrt_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [hkrt_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [hkrt_pkg::QUEUE_AW:0]   count_ff, count_in;
   logic                         do_push;
   logic                         do_pop;

   assign q_status.full  = (count_ff == (hkrt_pkg::QUEUE_AW + 1)'(hkrt_pkg::QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign do_push  = push && !q_status.full;
   assign do_pop   = pop && !q_status.empty;
   assign head_job = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == hkrt_pkg::QUEUE_AW'(hkrt_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == hkrt_pkg::QUEUE_AW'(hkrt_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

[rtl/hkrt_back.sv]
// Back end: plays each job's press and release steps on the report state.
// Holds dead key registers, modifier byte, key slots and the report register. Depends on hkrt_pkg.
module hkrt_back (
   input  logic                                clock,
   input  logic                                reset,
   input  hkrt_pkg::job_type                   head_job,
   input  hkrt_pkg::queue_status_type          q_status,
   output logic                                pop,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [hkrt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [hkrt_pkg::DEAD_W-1:0]         csr_wdata,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output hkrt_pkg::rsp_item_type              rsp_data
);

   hkrt_pkg::back_state_type state_ff, state_in;
   hkrt_pkg::job_type        job_ff, job_in;
   logic [hkrt_pkg::TYPE_STEPS-1:0] mask_ff, mask_in;
   logic [hkrt_pkg::STEP_W-1:0]     step_ff, step_in;
   logic [hkrt_pkg::DEAD_W-1:0]     dead_ff [hkrt_pkg::DEAD_KEYS];
   logic [7:0]                      mod_ff, mod_in;
   logic [7:0]                      slot_ff [hkrt_pkg::KEY_SLOTS];
   logic [7:0]                      slot_in [hkrt_pkg::KEY_SLOTS];
   logic                            rsp_valid_ff, rsp_valid_in;
   hkrt_pkg::rsp_item_type          rsp_data_ff, rsp_data_in;

   logic [3:0]  head_dead;
   logic        head_dead_ok;
   logic [hkrt_pkg::TYPE_STEPS-1:0] head_mask;
   logic [3:0]  job_dtype;
   logic        step_press;
   logic [3:0]  step_type;
   logic [7:0]  step_code;
   logic        step_use;
   logic [hkrt_pkg::DEAD_W-1:0] dc;
   logic [7:0]  key;
   logic        hit;
   logic        placed;
   logic        out_free;
   logic        exec;
   logic [7:0]  rpt_slot [hkrt_pkg::RPT_SLOTS];

   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign head_dead    = head_job.entry[15:12];
   assign head_dead_ok = (head_dead inside {[4'd1:4'd6]});

   always_comb begin
      head_mask = '0;
      if (head_job.command == hkrt_pkg::CMD_TYPE) begin
         head_mask[hkrt_pkg::STEP_DEAD_PRESS]    = head_dead_ok;
         head_mask[hkrt_pkg::STEP_SHIFT_PRESS]   = head_job.entry[hkrt_pkg::FLAG_SHIFT];
         head_mask[hkrt_pkg::STEP_ALTGR_PRESS]   = head_job.entry[hkrt_pkg::FLAG_ALTGR];
         head_mask[hkrt_pkg::STEP_KEY_PRESS]     = 1'b1;
         head_mask[hkrt_pkg::STEP_KEY_RELEASE]   = 1'b1;
         head_mask[hkrt_pkg::STEP_ALTGR_RELEASE] = head_job.entry[hkrt_pkg::FLAG_ALTGR];
         head_mask[hkrt_pkg::STEP_SHIFT_RELEASE] = head_job.entry[hkrt_pkg::FLAG_SHIFT];
         head_mask[hkrt_pkg::STEP_DEAD_RELEASE]  = head_dead_ok;
      end else begin
         head_mask[0] = (head_job.key_type <= hkrt_pkg::KT_DEAD_LAST);
      end
   end

   assign job_dtype = job_ff.entry[15:12] + 4'd2;

   // decode the current step
   always_comb begin
      step_press = (job_ff.command == hkrt_pkg::CMD_PRESS);
      step_type  = job_ff.key_type;
      step_code  = job_ff.key_code;
      step_use   = job_ff.use_mod;
      if (job_ff.command == hkrt_pkg::CMD_TYPE) begin
         step_press = !step_ff[hkrt_pkg::STEP_W-1];
         step_use   = 1'b1;
         case (step_ff)
            hkrt_pkg::STEP_DEAD_PRESS, hkrt_pkg::STEP_DEAD_RELEASE: begin
               step_type = job_dtype;
               step_code = 8'h00;
            end
            hkrt_pkg::STEP_SHIFT_PRESS, hkrt_pkg::STEP_SHIFT_RELEASE: begin
               step_type = hkrt_pkg::KT_MODIFIER;
               step_code = hkrt_pkg::MOD_LSHIFT;
            end
            hkrt_pkg::STEP_ALTGR_PRESS, hkrt_pkg::STEP_ALTGR_RELEASE: begin
               step_type = hkrt_pkg::KT_MODIFIER;
               step_code = hkrt_pkg::MOD_RALT;
            end
            default: begin
               step_type = hkrt_pkg::KT_CHAR;
               step_code = job_ff.key_code;
            end
         endcase
      end
   end

   always_comb begin
      dc = '0;
      if (step_type == hkrt_pkg::KT_SPECIAL) begin
         dc = {2'b00, step_code};
      end else if (step_type == hkrt_pkg::KT_CHAR) begin
         dc = job_ff.entry[hkrt_pkg::DEAD_W-1:0];
      end else if (step_type inside {[hkrt_pkg::KT_DEAD_FIRST:hkrt_pkg::KT_DEAD_LAST]}) begin
         dc = dead_ff[hkrt_pkg::CSR_IDX_W'(step_type - hkrt_pkg::KT_DEAD_FIRST)];
      end
   end

   assign key  = dc[7:0];
   assign exec = (state_ff == hkrt_pkg::B_RUN) && mask_ff[step_ff] && out_free;

   // apply the step to modifier byte and slots
   always_comb begin
      mod_in = mod_ff;
      hit    = 1'b0;
      placed = 1'b0;
      for (int i = 0; i < hkrt_pkg::KEY_SLOTS; i++) begin
         slot_in[i] = slot_ff[i];
         if (slot_ff[i] == key) begin
            hit = 1'b1;
         end
      end
      if (exec) begin
         if (step_press) begin
            if (step_type == hkrt_pkg::KT_MODIFIER) begin
               mod_in = mod_in | step_code;
            end
            if (step_use && step_type >= hkrt_pkg::KT_CHAR) begin
               if (dc[hkrt_pkg::FLAG_SHIFT]) begin
                  mod_in = mod_in | hkrt_pkg::MOD_LSHIFT;
               end
               if (dc[hkrt_pkg::FLAG_ALTGR]) begin
                  mod_in = mod_in | hkrt_pkg::MOD_RALT;
               end
            end
            if (!hit) begin
               for (int i = 0; i < hkrt_pkg::KEY_SLOTS; i++) begin
                  if (!placed && slot_ff[i] == 8'h00) begin
                     slot_in[i] = key;
                     placed     = 1'b1;
                  end
               end
            end
         end else begin
            if (step_type == hkrt_pkg::KT_MODIFIER) begin
               mod_in = mod_in & ~step_code;
            end
            if (step_type >= hkrt_pkg::KT_CHAR) begin
               if (dc[hkrt_pkg::FLAG_SHIFT]) begin
                  mod_in = mod_in & ~hkrt_pkg::MOD_LSHIFT;
               end
               if (dc[hkrt_pkg::FLAG_ALTGR]) begin
                  mod_in = mod_in & ~hkrt_pkg::MOD_RALT;
               end
            end
            for (int i = 0; i < hkrt_pkg::KEY_SLOTS; i++) begin
               if (slot_ff[i] == key) begin
                  slot_in[i] = 8'h00;
               end
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < hkrt_pkg::RPT_SLOTS; i++) begin
         rpt_slot[i] = 8'h00;
      end
      for (int i = 0; i < hkrt_pkg::KEY_SLOTS; i++) begin
         if (i < hkrt_pkg::RPT_SLOTS) begin
            rpt_slot[i] = slot_in[i];
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      mask_in      = mask_ff;
      step_in      = step_ff;
      pop          = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         hkrt_pkg::B_IDLE: begin
            if (!q_status.empty) begin
               pop     = 1'b1;
               job_in  = head_job;
               mask_in = head_mask;
               step_in = '0;
               if (head_mask != '0) begin
                  state_in = hkrt_pkg::B_RUN;
               end
            end
         end
         hkrt_pkg::B_RUN: begin
            if (!mask_ff[step_ff]) begin
               step_in = step_ff + 1'b1;
            end else if (exec) begin
               mask_in      = mask_ff & ~(hkrt_pkg::TYPE_STEPS'(1) << step_ff);
               step_in      = step_ff + 1'b1;
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{modifiers: mod_in,
                                slot_zero: rpt_slot[0], slot_one: rpt_slot[1],
                                slot_two: rpt_slot[2], slot_three: rpt_slot[3],
                                slot_four: rpt_slot[4], slot_five: rpt_slot[5],
                                last: (mask_in == '0)};
               if (mask_in == '0) begin
                  state_in = hkrt_pkg::B_IDLE;
               end
            end
         end
         default: begin
            state_in = hkrt_pkg::B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hkrt_pkg::B_IDLE;
         mask_ff      <= '0;
         step_ff      <= '0;
         mod_ff       <= 8'h00;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < hkrt_pkg::KEY_SLOTS; i++) begin
            slot_ff[i] <= 8'h00;
         end
         for (int i = 0; i < hkrt_pkg::DEAD_KEYS; i++) begin
            dead_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         mask_ff      <= mask_in;
         step_ff      <= step_in;
         mod_ff       <= mod_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < hkrt_pkg::KEY_SLOTS; i++) begin
            slot_ff[i] <= slot_in[i];
         end
         if (csr_valid && csr_ready &&
             csr_index < hkrt_pkg::CSR_IDX_W'(hkrt_pkg::DEAD_KEYS)) begin
            dead_ff[csr_index] <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

[tb/hid_keyboard_report_tracker_top_tb.sv]
// Self-checking testbench for hid_keyboard_report_tracker_top.
// Drives directed and random key commands, predicts every HID report and checks them in order.
// Depends on hkrt_pkg and the tracker RTL.
module hid_keyboard_report_tracker_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import hkrt_pkg::*;

   localparam int IDLE_LIMIT    = 2000;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 20;
   localparam int REQ_W         = $bits(req_item_type);
   localparam logic [3:0] KT_IGNORED = 4'd9;
   localparam logic [3:0] KT_TOP     = 4'd15;

   localparam logic [9:0] US_KEYS [128] = '{
      10'h000, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000,
      10'h02a, 10'h02b, 10'h028, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000,
      10'h000, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000,
      10'h000, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000,
      10'h02c, 10'h11e, 10'h134, 10'h120, 10'h121, 10'h122, 10'h124, 10'h034,
      10'h126, 10'h127, 10'h125, 10'h12e, 10'h036, 10'h02d, 10'h037, 10'h038,
      10'h027, 10'h01e, 10'h01f, 10'h020, 10'h021, 10'h022, 10'h023, 10'h024,
      10'h025, 10'h026, 10'h133, 10'h033, 10'h136, 10'h02e, 10'h137, 10'h138,
      10'h11f, 10'h104, 10'h105, 10'h106, 10'h107, 10'h108, 10'h109, 10'h10a,
      10'h10b, 10'h10c, 10'h10d, 10'h10e, 10'h10f, 10'h110, 10'h111, 10'h112,
      10'h113, 10'h114, 10'h115, 10'h116, 10'h117, 10'h118, 10'h119, 10'h11a,
      10'h11b, 10'h11c, 10'h11d, 10'h02f, 10'h031, 10'h030, 10'h123, 10'h12d,
      10'h035, 10'h004, 10'h005, 10'h006, 10'h007, 10'h008, 10'h009, 10'h00a,
      10'h00b, 10'h00c, 10'h00d, 10'h00e, 10'h00f, 10'h010, 10'h011, 10'h012,
      10'h013, 10'h014, 10'h015, 10'h016, 10'h017, 10'h018, 10'h019, 10'h01a,
      10'h01b, 10'h01c, 10'h01d, 10'h12f, 10'h131, 10'h130, 10'h135, 10'h000
   };

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_item_type         req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_item_type         rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DEAD_W-1:0]    csr_wdata = '0;

   req_item_type keystrokes [$];
   rsp_item_type reports_due [$];
   rsp_item_type want;
   int           failures      = 0;
   int           sender_idle   = 0;
   int           receiver_idle = 0;
   int           phase_no      = 0;
   int           idle_cycles   = 0;
   logic         hold_rsp      = 1'b0;

   logic [7:0]  kb_mods;
   logic [7:0]  kb_slots [KEY_SLOTS];
   logic [15:0] kb_map [MAP_ENTRIES];
   logic [7:0]  utf_lead;
   logic [9:0]  dead_key [DEAD_KEYS];

   hid_keyboard_report_tracker_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic bit key_lookup(input logic [3:0] kt, input logic [7:0] code,
                                     output logic [15:0] dc);
      dc = 16'h0000;
      if (kt == KT_MODIFIER) begin
         dc = 16'h0000;
      end else if (kt == KT_SPECIAL) begin
         dc = {8'h00, code};
      end else if (kt == KT_CHAR) begin
         dc = kb_map[code];
      end else if (kt <= KT_DEAD_LAST) begin
         dc = {6'b000000, dead_key[int'(kt) - int'(KT_DEAD_FIRST)]};
      end else begin
         return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic bit key_down(input logic [3:0] kt, input logic [7:0] code,
                                   input logic with_mods);
      logic [15:0] dc;
      logic [7:0]  k;
      bit          found;
      if (!key_lookup(kt, code, dc)) return 1'b0;
      if (kt == KT_MODIFIER) kb_mods |= code;
      if (with_mods && kt >= KT_CHAR) begin
         if (dc[FLAG_SHIFT]) kb_mods |= MOD_LSHIFT;
         if (dc[FLAG_ALTGR]) kb_mods |= MOD_RALT;
      end
      k = dc[7:0];
      found = 1'b0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         if (kb_slots[i] == k) found = 1'b1;
      end
      for (int i = 0; i < KEY_SLOTS; i++) begin
         if (!found && kb_slots[i] == 8'h00) begin
            kb_slots[i] = k;
            found = 1'b1;
         end
      end
      return 1'b1;
   endfunction

   function automatic bit key_up(input logic [3:0] kt, input logic [7:0] code);
      logic [15:0] dc;
      if (!key_lookup(kt, code, dc)) return 1'b0;
      if (kt == KT_MODIFIER) kb_mods &= ~code;
      if (kt >= KT_CHAR) begin
         if (dc[FLAG_SHIFT]) kb_mods &= ~MOD_LSHIFT;
         if (dc[FLAG_ALTGR]) kb_mods &= ~MOD_RALT;
      end
      for (int i = 0; i < KEY_SLOTS; i++) begin
         if (kb_slots[i] == dc[7:0]) kb_slots[i] = 8'h00;
      end
      return 1'b1;
   endfunction

   function automatic logic [7:0] fold_text(input logic [7:0] b);
      logic [7:0] prev;
      if (!b[7]) begin
         utf_lead = 8'h00;
         return b;
      end
      prev = utf_lead;
      utf_lead = b;
      if (prev == UTF8_LEAD_C2) return b;
      if (prev == UTF8_LEAD_C3) return b | UTF8_HIGH_SET;
      if (prev == EURO_LEAD && b == EURO_TRAIL) return EURO_CHAR;
      return 8'h00;
   endfunction

   function automatic int post_report(input bit acted);
      rsp_item_type r;
      if (!acted) return 0;
      r.modifiers  = kb_mods;
      r.slot_zero  = kb_slots[0];
      r.slot_one   = kb_slots[1];
      r.slot_two   = kb_slots[2];
      r.slot_three = kb_slots[3];
      r.slot_four  = kb_slots[4];
      r.slot_five  = kb_slots[5];
      r.last       = 1'b0;
      reports_due.push_back(r);
      return 1;
   endfunction

   task automatic track_keystroke(input req_item_type it);
      int           n;
      logic [7:0]   c;
      logic [15:0]  dc;
      logic [3:0]   dead;
      logic [3:0]   dead_type;
      rsp_item_type r;
      n = 0;
      case (it.command)
         CMD_PRESS: n += post_report(key_down(it.key_type, it.key_code, it.use_mod));
         CMD_RELEASE: n += post_report(key_up(it.key_type, it.key_code));
         CMD_TYPE: begin
            c = fold_text(it.key_code);
            dc = (c != 8'h00) ? kb_map[c] : 16'h0000;
            if (dc != 16'h0000) begin
               dead = dc[15:12];
               dead_type = (dead >= 4'd1 && dead <= 4'd6) ? KT_DEAD_FIRST + dead - 4'd1
                                                          : KT_IGNORED;
               if (dead != 4'd0) n += post_report(key_down(dead_type, 8'h00, 1'b1));
               if (dc[FLAG_SHIFT]) n += post_report(key_down(KT_MODIFIER, MOD_LSHIFT, 1'b1));
               if (dc[FLAG_ALTGR]) n += post_report(key_down(KT_MODIFIER, MOD_RALT, 1'b1));
               n += post_report(key_down(KT_CHAR, c, 1'b1));
               n += post_report(key_up(KT_CHAR, c));
               if (dc[FLAG_ALTGR]) n += post_report(key_up(KT_MODIFIER, MOD_RALT));
               if (dc[FLAG_SHIFT]) n += post_report(key_up(KT_MODIFIER, MOD_LSHIFT));
               if (dead != 4'd0) n += post_report(key_up(dead_type, 8'h00));
            end
         end
         default: kb_map[it.key_code] = it.map_entry;
      endcase
      if (n > 0) begin
         r = reports_due.pop_back();
         r.last = 1'b1;
         reports_due.push_back(r);
      end
   endtask

   task automatic queue_key(input command_type cmd, input logic [3:0] kt,
                            input logic [7:0] code, input logic um, input logic [15:0] entry);
      req_item_type it;
      it.command   = cmd;
      it.key_type  = kt;
      it.key_code  = code;
      it.use_mod   = um;
      it.map_entry = entry;
      keystrokes.push_back(it);
   endtask

   function automatic logic [3:0] pick_key_type();
      int r;
      r = $urandom_range(15);
      if (r < 3) return KT_MODIFIER;
      if (r < 6) return KT_SPECIAL;
      if (r < 10) return KT_CHAR;
      if (r < 14) return KT_DEAD_FIRST + 4'($urandom_range(5));
      return 4'($urandom_range(15, 9));
   endfunction

   function automatic logic [7:0] pick_key_code(input logic [3:0] kt);
      if (kt == KT_SPECIAL && $urandom_range(3) != 0) return 8'($urandom_range(11, 4));
      if (kt == KT_CHAR && $urandom_range(3) != 0) return 8'($urandom_range(126, 32));
      return 8'($urandom_range(255));
   endfunction

   task automatic add_random_keys(input int count);
      req_item_type it;
      int           added;
      int           r;
      logic [7:0]   lead;
      added = 0;
      while (added < count) begin
         it = REQ_W'($urandom());
         r = $urandom_range(99);
         if (r < 22) begin
            it.command  = CMD_PRESS;
            it.key_type = pick_key_type();
            it.key_code = pick_key_code(it.key_type);
         end else if (r < 40) begin
            it.command  = CMD_RELEASE;
            it.key_type = pick_key_type();
            it.key_code = pick_key_code(it.key_type);
         end else if (r < 88) begin
            it.command = CMD_TYPE;
            r = $urandom_range(99);
            if (r < 5) begin
               it.key_code = 8'($urandom_range(10, 8));
            end else if (r < 65) begin
               it.key_code = 8'($urandom_range(126, 32));
            end else if (r < 85) begin
               if (r < 80) lead = ($urandom_range(1) != 0) ? UTF8_LEAD_C2 : UTF8_LEAD_C3;
               else lead = EURO_LEAD;
               it.key_code = lead;
               keystrokes.push_back(it);
               added++;
               it.key_code = (lead == EURO_LEAD) ? EURO_TRAIL : 8'($urandom_range(255, 128));
            end else begin
               it.key_code = 8'($urandom_range(255));
            end
         end else begin
            it.command  = CMD_WRITE;
            it.key_code = ($urandom_range(1) != 0) ? 8'($urandom_range(255, 128))
                                                   : 8'($urandom_range(255));
         end
         keystrokes.push_back(it);
         added++;
      end
   endtask

   task automatic program_dead_keys(input logic [DEAD_KEYS-1:0][DEAD_W-1:0] vals);
      csr_valid <= 1'b1;
      for (int i = 0; i < DEAD_KEYS; i++) begin
         csr_index <= i[CSR_IDX_W-1:0];
         csr_wdata <= vals[i];
         do @(posedge clock); while (!csr_ready);
         dead_key[i] = vals[i];
      end
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      do @(negedge clock); while (keystrokes.size() != 0 || req_valid || reports_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) track_keystroke(req_data);
         if (!req_valid || !req_stall) begin
            if (keystrokes.size() != 0 && $urandom_range(99) >= sender_idle) begin
               req_data  <= keystrokes.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (reports_due.size() == 0) begin
               failures++;
               if (failures <= 10) $display("report with none pending: %h", rsp_data);
            end else begin
               want = reports_due.pop_front();
               if (rsp_data.modifiers !== want.modifiers || rsp_data.slot_zero !== want.slot_zero ||
                   rsp_data.slot_one !== want.slot_one || rsp_data.slot_two !== want.slot_two ||
                   rsp_data.slot_three !== want.slot_three ||
                   rsp_data.slot_four !== want.slot_four ||
                   rsp_data.slot_five !== want.slot_five || rsp_data.last !== want.last) begin
                  failures++;
                  if (failures <= 10)
                     $display("report mismatch: want mods %h slots %h %h %h %h %h %h last %b, got mods %h slots %h %h %h %h %h %h last %b",
                              want.modifiers, want.slot_zero, want.slot_one, want.slot_two,
                              want.slot_three, want.slot_four, want.slot_five, want.last,
                              rsp_data.modifiers, rsp_data.slot_zero, rsp_data.slot_one,
                              rsp_data.slot_two, rsp_data.slot_three, rsp_data.slot_four,
                              rsp_data.slot_five, rsp_data.last);
               end
            end
         end
         rsp_stall <= hold_rsp || ($urandom_range(99) < receiver_idle);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // hold off the receiver so the block backs up and stalls its input
   initial begin
      wait (phase_no == 3);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin
      logic [DEAD_KEYS-1:0][DEAD_W-1:0] cfg;
      for (int i = 0; i < MAP_ENTRIES; i++) begin
         kb_map[i] = 16'h0000;
         if (i < 128) kb_map[i] = {6'b000000, US_KEYS[i]};
      end
      for (int i = 0; i < KEY_SLOTS; i++) kb_slots[i] = 8'h00;
      for (int i = 0; i < DEAD_KEYS; i++) begin
         dead_key[i] = '0;
         cfg[i] = DEAD_W'($urandom_range(1023));
      end
      kb_mods  = 8'h00;
      utf_lead = 8'h00;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      sender_idle   <= 15;
      receiver_idle <= 77;
      program_dead_keys(cfg);
      queue_key(CMD_PRESS, KT_MODIFIER, 8'hff, 1'b1, 16'h0000);
      queue_key(CMD_RELEASE, KT_MODIFIER, 8'hff, 1'b0, 16'hffff);
      for (int k = 4; k <= 10; k++) queue_key(CMD_PRESS, KT_SPECIAL, 8'(k), 1'b0, 16'h0000);
      queue_key(CMD_RELEASE, KT_SPECIAL, 8'h00, 1'b0, 16'h0000);
      queue_key(CMD_PRESS, KT_SPECIAL, 8'h00, 1'b1, 16'h0000);
      queue_key(CMD_RELEASE, KT_SPECIAL, 8'h05, 1'b0, 16'h0000);
      queue_key(CMD_PRESS, KT_CHAR, 8'h41, 1'b1, 16'h0000);
      queue_key(CMD_RELEASE, KT_CHAR, 8'h41, 1'b0, 16'h0000);
      queue_key(CMD_PRESS, KT_DEAD_FIRST, 8'h00, 1'b1, 16'h0000);
      queue_key(CMD_RELEASE, KT_DEAD_LAST, 8'hff, 1'b0, 16'h0000);
      queue_key(CMD_PRESS, KT_IGNORED, 8'h04, 1'b1, 16'h0000);
      queue_key(CMD_RELEASE, KT_TOP, 8'h04, 1'b0, 16'h0000);
      queue_key(CMD_WRITE, KT_CHAR, 8'hff, 1'b0, 16'hffff);
      queue_key(CMD_WRITE, KT_CHAR, EURO_CHAR, 1'b0, 16'h1305);
      queue_key(CMD_TYPE, KT_CHAR, EURO_LEAD, 1'b0, 16'h0000);
      queue_key(CMD_TYPE, KT_CHAR, EURO_TRAIL, 1'b0, 16'h0000);
      queue_key(CMD_TYPE, KT_CHAR, UTF8_LEAD_C3, 1'b0, 16'h0000);
      queue_key(CMD_TYPE, KT_CHAR, 8'hbf, 1'b0, 16'h0000);
      queue_key(CMD_TYPE, KT_CHAR, 8'h00, 1'b0, 16'h0000);
      queue_key(CMD_TYPE, KT_CHAR, 8'h61, 1'b1, 16'h0000);
      queue_key(CMD_TYPE, KT_CHAR, 8'h90, 1'b0, 16'h0000);
      add_random_keys(37);
      wait_drained();

      sender_idle   <= 77;
      receiver_idle <= 15;
      program_dead_keys({DEAD_KEYS{10'h3ff}});
      add_random_keys(37);
      wait_drained();

      sender_idle   <= 0;
      receiver_idle <= 0;
      program_dead_keys('0);
      add_random_keys(36);
      phase_no <= 3;
      wait_drained();

      if (reports_due.size() != 0) begin
         failures++;
         $display("%0d reports never arrived", reports_due.size());
      end
      if (failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
